/* hdl/d2di_pkg.sv */
`timescale 1ns / 1ps

package d2di_pkg;

    // Field widths
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned INDEX_W = 24;

    // Packed stream widths, padded to whole bytes
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 24;

    // Calendar constants
    localparam logic [YEAR_W-1:0]         EPOCH_YEAR = 12'd2000;
    // Days from the start of year 0 to 1 January 2000: 365*2000 + 500
    localparam logic signed [INDEX_W-1:0] EPOCH_DAYS = 24'sd730500;
    localparam logic signed [INDEX_W-1:0] LIMIT_POS  = 24'sd5000000;
    localparam logic signed [INDEX_W-1:0] LIMIT_NEG  = -24'sd5000000;

    // Month codes
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_d2di_date;

    typedef struct packed {
        logic                      date_valid;
        logic signed [INDEX_W-1:0] day_index;
    } t_d2di_res;

    // Length of a month in a common year; zero for codes that are no month
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:                                      len = 5'd28;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in the months before month m of a common year
    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [8:0] d;
        unique case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

/* hdl/d2di_calc.sv */
`timescale 1ns / 1ps

module d2di_calc
    import d2di_pkg::*;
(
    input  t_d2di_date i_date,
    output t_d2di_res  o_res
);

    logic                      leap;
    logic [DAY_W-1:0]          len;
    logic                      ok;
    logic [20:0]               year_days;
    logic [10:0]               leap_days;
    logic [12:0]               year_p3;
    logic [21:0]               abs_days;
    logic signed [INDEX_W-1:0] idx;

    // Check that the date exists under the every-fourth-year leap rule
    always_comb begin
        leap = (i_date.year[1:0] == 2'b00);
        len  = month_len(i_date.month);
        if (i_date.month == MONTH_FEB && leap) begin
            len = 5'd29;
        end
        ok = (i_date.month >= MONTH_JAN) && (i_date.month <= MONTH_DEC) &&
             (i_date.day != '0) && (i_date.day <= len);
    end

    // Count days from the start of year 0, then move the origin to 2000
    always_comb begin
        year_days = 21'(i_date.year) * 21'd365;
        year_p3   = 13'(i_date.year) + 13'd3;
        leap_days = year_p3[12:2];
        abs_days  = 22'(year_days) + 22'(leap_days)
                  + 22'(days_before_month(i_date.month))
                  + 22'((i_date.month > MONTH_FEB) && leap)
                  + 22'(i_date.day) - 22'd1;
        idx       = $signed({2'b00, abs_days}) - EPOCH_DAYS;
    end

    // Saturate invalid dates toward the side of the epoch they fall on
    always_comb begin
        o_res.date_valid = ok;
        if (ok) begin
            o_res.day_index = idx;
        end else if (i_date.year >= EPOCH_YEAR) begin
            o_res.day_index = LIMIT_POS;
        end else begin
            o_res.day_index = LIMIT_NEG;
        end
    end

endmodule

/* hdl/date_to_day_index_unit.sv */
`timescale 1ns / 1ps

// Channel | Direction | tdata (low bit up)                 | tuser
// s_axis  | in        | year[11:0] month[15:12] day[20:16] | -
// m_axis  | out       | day_index[23:0] (signed)           | date_valid[0]
//
// One item per cycle sustained while m_axis is ready. An accepted item sits in the
// input register, then moves on into the result register and shows on m_axis.
// The conversion between the two registers is a constant multiply by 365,
// a month table and one adder chain. i_rst_n is synchronous, active low,
// and empties both stages. A stall on m_axis holds the result register and
// backs up into the input register; s_axis stays ready while either has room.

module date_to_day_index_unit
    import d2di_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // year[11:0], month[15:12], day[20:16], zero pad
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // day_index[23:0]
    output logic [0:0]           m_axis_tuser    // date_valid[0]
);

    logic       r_in_v,  n_in_v;
    logic       r_out_v, n_out_v;
    t_d2di_date r_date;
    t_d2di_res  r_res;
    t_d2di_res  calc_res;
    logic       out_load;
    logic       in_load;

    // Advance a stage when the one after it has room
    assign out_load      = !r_out_v || m_axis_tready;
    assign s_axis_tready = !r_in_v || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_in_v  = r_in_v;
        n_out_v = r_out_v;
        if (out_load) begin
            n_out_v = r_in_v;
        end
        if (s_axis_tready) begin
            n_in_v = s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_in_v  <= n_in_v;
            r_out_v <= n_out_v;
        end
    end

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_date <= t_d2di_date'(s_axis_tdata[$bits(t_d2di_date)-1:0]);
        end
    end

    d2di_calc u_calc (
        .i_date (r_date),
        .o_res  (calc_res)
    );

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (out_load && r_in_v) begin
            r_res <= calc_res;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_res.day_index;
    assign m_axis_tuser  = r_res.date_valid;

    // An invalid date always leaves with one of the two limit values
    a_invalid_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |->
        ($signed(m_axis_tdata) == LIMIT_POS || $signed(m_axis_tdata) == LIMIT_NEG))
        else $error("invalid date without limit index");

    // A valid date never lies before year 0
    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> ($signed(m_axis_tdata) >= -EPOCH_DAYS))
        else $error("valid index before year 0");

    // A held item in the input stage is not dropped while the output stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && !out_load) |=> (r_in_v && $stable(r_date)))
        else $error("input stage lost an item under stall");

    // An item in the input stage moves to the output when the output has room
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && out_load) |=> m_axis_tvalid)
        else $error("item not moved to output stage");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && !r_in_v))
        else $error("pipeline not empty after reset");

endmodule
